// ===== design/dfsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfsp_pkg;

   localparam int Side       = 5;
   localparam int PixelCount = Side * Side;
   localparam int ColorW     = 24;
   localparam int PosW       = 5;
   localparam int DigitW     = 4;

   localparam logic [ColorW-1:0] ColorReset = 24'h0A0A0A;
   localparam logic [PosW-1:0]   LastPos    = PosW'(PixelCount - 1);

   // Glyph rows, bit 4 is the leftmost column
   localparam logic [Side-1:0] RowFull   = 5'b11111;
   localparam logic [Side-1:0] RowRight  = 5'b00001;
   localparam logic [Side-1:0] RowLeft   = 5'b10000;
   localparam logic [Side-1:0] RowSides  = 5'b10001;
   localparam logic [Side-1:0] RowInner  = 5'b01110;
   localparam logic [Side-1:0] RowCentre = 5'b00100;
   localparam logic [Side-1:0] RowTail   = 5'b00111;
   localparam logic [Side-1:0] RowStem2  = 5'b01100;
   localparam logic [Side-1:0] RowHook   = 5'b10010;
   localparam logic [Side-1:0] RowDiag   = 5'b01000;
   localparam logic [Side-1:0] RowBlank  = 5'b00000;

   // Five rows of a frame, top first
   typedef logic [Side-1:0] row_type;
   typedef struct packed {
      row_type top;
      row_type second;
      row_type middle;
      row_type fourth;
      row_type bottom;
   } frame_type;

   // Frame load from the mapper to the emitter, mask bit 0 is chain position 0
   typedef struct packed {
      logic                  load;
      logic [PixelCount-1:0] mask;
   } load_type;

   function automatic frame_type font_rows(input logic [DigitW-1:0] digit);
      frame_type f;
      unique case (digit)
         4'd0: f = '{RowFull, RowSides, RowSides, RowSides, RowFull};
         4'd1: f = '{RowCentre, RowStem2, RowCentre, RowCentre, RowInner};
         4'd2: f = '{RowInner, RowHook, RowCentre, RowDiag, RowFull};
         4'd3: f = '{RowFull, RowRight, RowTail, RowRight, RowFull};
         4'd4: f = '{RowSides, RowSides, RowFull, RowRight, RowRight};
         4'd5: f = '{RowFull, RowLeft, RowFull, RowRight, RowFull};
         4'd6: f = '{RowFull, RowLeft, RowFull, RowSides, RowFull};
         4'd7: f = '{RowFull, RowRight, RowRight, RowRight, RowRight};
         4'd8: f = '{RowFull, RowSides, RowFull, RowSides, RowFull};
         4'd9: f = '{RowFull, RowSides, RowFull, RowRight, RowRight};
         default: f = '{RowBlank, RowBlank, RowBlank, RowBlank, RowBlank};
      endcase
      return f;
   endfunction

   function automatic row_type row_reverse(input row_type r);
      row_type o;
      for (int i = 0; i < Side; i++) begin
         o[i] = r[Side-1-i];
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// ===== design/dfsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dfsp_req_if;
   logic       valid;
   logic       ready;
   logic       use_font;
   logic [3:0] digit;
   logic [4:0] row_top;
   logic [4:0] row_second;
   logic [4:0] row_middle;
   logic [4:0] row_fourth;
   logic [4:0] row_bottom;

   modport source (output valid, use_font, digit, row_top, row_second, row_middle,
                   row_fourth, row_bottom, input ready);
   modport sink   (input valid, use_font, digit, row_top, row_second, row_middle,
                   row_fourth, row_bottom, output ready);
endinterface

interface dfsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_word;
   logic [4:0]  chain_position;
   logic        last_pixel;

   modport source (output valid, pixel_word, chain_position, last_pixel, input ready);
   modport sink   (input valid, pixel_word, chain_position, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== design/digit_frame_to_serpentine_pixels_core.sv =====
// Renders a 5x5 frame onto a 25-LED serpentine chain, one pixel word at a time.
// Request channel (req_ch): one word per frame, either five row masks or a
//   digit looked up in the built-in font (use_font). Digits ten to fifteen
//   render a blank frame.
// Response channel (rsp_ch): 25 words per frame in chain order, bottom row
//   right to left, then the next row left to right, and so on upwards. Each
//   word carries the lit colour or zero, its chain position, and last_pixel
//   on position 24.
// CSR port: csr_write_en / csr_write_data set the lit GRB colour; write only
//   while no frame is in flight. Reset value is 0x0A0A0A.
// The request word is loaded into the 25-bit mask shift register, which
//   releases one bit per cycle into the output register unless the receiver
//   stalls; the next frame is taken in the cycle its predecessor's last bit
//   moves to the output register.
// Reset: synchronous, active high; drops any frame in flight and restores the
//   colour. Receiver stall: the output register holds its word and the shift
//   register holds until rsp_ch.ready returns; no word is lost.
`timescale 1ns / 1ps
`default_nettype none

module digit_frame_to_serpentine_pixels_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   dfsp_req_if.sink                         req_ch,
   dfsp_rsp_if.source                       rsp_ch,
   input  wire logic                        csr_write_en,
   input  wire logic [dfsp_pkg::ColorW-1:0] csr_write_data
);
   import dfsp_pkg::*;

   load_type  frame_load;
   frame_type req_rows;
   logic      load_ready;

   // Gather the row fields, top row first
   assign req_rows = '{req_ch.row_top, req_ch.row_second, req_ch.row_middle,
                       req_ch.row_fourth, req_ch.row_bottom};

   assign req_ch.ready = load_ready;

   // Map the frame onto chain order; load fires on the request handshake
   dfsp_frame_map u_map (
      .use_font  (req_ch.use_font),
      .digit     (req_ch.digit),
      .rows      (req_rows),
      .frame_out (frame_load),
      .load      (req_ch.valid && load_ready)
   );

   // Shift the chain mask out a bit per cycle into the output register unless rsp_ch stalls
   dfsp_pixel_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .frame_in       (frame_load),
      .load_ready     (load_ready),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp            (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== design/dfsp_frame_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfsp_frame_map (
   input  wire logic                           use_font,
   input  wire logic [dfsp_pkg::DigitW-1:0]    digit,
   input  wire dfsp_pkg::frame_type            rows,
   output dfsp_pkg::load_type                  frame_out,
   input  wire logic                           load
);
   import dfsp_pkg::*;

   frame_type f;

   // Select rows, then lay them onto the chain: even bands run right to left
   always_comb begin
      f = use_font ? font_rows(digit) : rows;
      frame_out.load = load;
      frame_out.mask = {f.top, row_reverse(f.second), f.middle,
                        row_reverse(f.fourth), f.bottom};
   end

endmodule

`default_nettype wire

// ===== design/dfsp_pixel_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfsp_pixel_emit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dfsp_pkg::load_type          frame_in,
   output logic                             load_ready,
   input  wire logic                        csr_write_en,
   input  wire logic [dfsp_pkg::ColorW-1:0] csr_write_data,
   dfsp_rsp_if.source                       rsp
);
   import dfsp_pkg::*;

   logic [ColorW-1:0]     color_ff, color_in;
   logic [PixelCount-1:0] mask_ff, mask_in;
   logic [PosW-1:0]       pos_ff, pos_in;
   logic                  busy_ff, busy_in;
   logic                  ovalid_ff, ovalid_in;
   logic [ColorW-1:0]     oword_ff, oword_in;
   logic [PosW-1:0]       opos_ff, opos_in;
   logic                  olast_ff, olast_in;
   logic                  advance;
   logic                  at_last;

   assign advance    = busy_ff && (!ovalid_ff || rsp.ready);
   assign at_last    = (pos_ff == LastPos);
   assign load_ready = !busy_ff || (advance && at_last);

   always_comb begin
      color_in  = csr_write_en ? csr_write_data : color_ff;
      mask_in   = mask_ff;
      pos_in    = pos_ff;
      busy_in   = busy_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      oword_in  = oword_ff;
      opos_in   = opos_ff;
      olast_in  = olast_ff;
      if (advance) begin
         // Move one bit of the mask into the output word
         ovalid_in = 1'b1;
         oword_in  = mask_ff[0] ? color_ff : '0;
         opos_in   = pos_ff;
         olast_in  = at_last;
         mask_in   = mask_ff >> 1;
         pos_in    = pos_ff + PosW'(1);
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (frame_in.load) begin
         mask_in = frame_in.mask;
         pos_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff  <= ColorReset;
         pos_ff    <= '0;
         busy_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         color_ff  <= color_in;
         pos_ff    <= pos_in;
         busy_ff   <= busy_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff  <= mask_in;
      oword_ff <= oword_in;
      opos_ff  <= opos_in;
      olast_ff <= olast_in;
   end

   assign rsp.valid          = ovalid_ff;
   assign rsp.pixel_word     = oword_ff;
   assign rsp.chain_position = opos_ff;
   assign rsp.last_pixel     = olast_ff;

endmodule

`default_nettype wire
